// File: hdl/keyed_list_table_assert.svh
// Assertion macros for the keyed list table.
`ifndef KEYED_LIST_TABLE_ASSERT_SVH
`define KEYED_LIST_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset
`define KLT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define KLT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define KLT_ASSERT(lbl, clk, rst_n, prop, msg)
`define KLT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: hdl/klt_pkg.sv
package klt_pkg;

	// Table geometry
	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Field widths of a transaction
	localparam int KEY_W = 64;
	localparam int QTY_W = 32;
	localparam int POS_W = 4;
	localparam int COUNT_W = 5;

	// Command codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;
	localparam logic [1:0] MODE_LIST   = 2'd3;

	// Status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

	// Cell load codes
	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_NEXT  = 2'd1;
	localparam logic [1:0] CELL_WRITE = 2'd2;

	typedef struct packed {
		logic [1:0]              mode;
		logic [KEY_W-1:0]        item_name;
		logic [KEY_W-1:0]        item_kind;
		logic signed [QTY_W-1:0] item_quantity;
	} cmd_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [POS_W-1:0]        position;
		logic [COUNT_W-1:0]      entry_count;
		logic [KEY_W-1:0]        found_name;
		logic [KEY_W-1:0]        found_kind;
		logic signed [QTY_W-1:0] found_quantity;
		logic                    last_of_run;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]        name;
		logic [KEY_W-1:0]        kind;
		logic signed [QTY_W-1:0] quantity;
	} entry_t;

	typedef struct packed {
		logic [1:0] op;
	} cell_ctl_t;

endpackage

// File: hdl/klt_cell.sv
// One table slot: holds an entry, loads from its neighbor or the write bus.
module klt_cell (
	input  logic               clk,
	input  klt_pkg::cell_ctl_t ctl,
	input  klt_pkg::entry_t    wr_data,
	input  klt_pkg::entry_t    nxt,
	output klt_pkg::entry_t    ent
);

	klt_pkg::entry_t ent_q;

	// entry register, no reset (contents undefined until written)
	always_ff @(posedge clk) begin
		case (ctl.op)
			klt_pkg::CELL_WRITE: ent_q <= wr_data;
			klt_pkg::CELL_NEXT:  ent_q <= nxt;
			default:             ent_q <= ent_q;
		endcase
	end

	assign ent = ent_q;

endmodule

// File: hdl/keyed_list_table.sv
// Keyed list table: an ordered table of up to 16 entries (64-bit name, 64-bit kind,
// signed 32-bit quantity) kept in a ring of cells that is read only at cell 0.
// Insert writes the slot after the last entry and answers through the pending
// register and then the output register. Search, remove and list rotate the ring
// one place per cycle (a list holds while its last result waits untaken) for a
// full turn of 16 places so that every entry passes cell 0, which brings the ring
// back to its start; a remove then, in the decide state, moves the later entries
// down one cell at once. Commands on an empty table and inserts into a full one
// answer without a scan. One command is worked on at a time; a new command is
// taken while the last result still waits in the output register.
module keyed_list_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  klt_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output klt_pkg::rsp_t  res
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_REPORT = 2'd3;

	logic [1:0]                  state_q;
	logic [klt_pkg::CNT_W-1:0]   step_q;
	logic [klt_pkg::CNT_W-1:0]   count_q;
	logic                        found_q;
	logic                        res_valid_q;
	logic [1:0]                  mode_q;
	logic [klt_pkg::KEY_W-1:0]   key_q;
	logic [klt_pkg::IDX_W-1:0]   hit_idx_q;
	klt_pkg::entry_t             hit_ent_q;
	klt_pkg::rsp_t               pend_q;
	klt_pkg::rsp_t               res_q;

	klt_pkg::entry_t             cell_ent [klt_pkg::CAPACITY];
	klt_pkg::cell_ctl_t          cell_ctl [klt_pkg::CAPACITY];
	klt_pkg::entry_t             wr_ent;
	klt_pkg::rsp_t               pend_d;
	klt_pkg::rsp_t               list_rsp;

	logic cmd_fire, slot_free, in_range, key_hit, list_mode, scan_adv, list_emit;
	logic last_step, shift, ins_wr, report_load, pend_load, table_full, table_empty;

	// handshake and scan control
	assign cmd_ready   = (state_q == ST_IDLE);
	assign cmd_fire    = cmd_valid && cmd_ready;
	assign slot_free   = !res_valid_q || res_ready;
	assign table_full  = (count_q == klt_pkg::CNT_W'(klt_pkg::CAPACITY));
	assign table_empty = (count_q == '0);
	assign in_range    = (step_q < count_q);
	assign list_mode   = (mode_q == klt_pkg::MODE_LIST);
	assign key_hit     = in_range && !found_q && (cell_ent[0].name == key_q);
	assign scan_adv    = (state_q == ST_SCAN) && (!list_mode || !in_range || slot_free);
	assign list_emit   = scan_adv && list_mode && in_range;
	assign last_step   = (step_q == klt_pkg::CNT_W'(klt_pkg::CAPACITY - 1));
	assign shift       = (state_q == ST_DECIDE) && (mode_q == klt_pkg::MODE_REMOVE) && found_q;
	assign ins_wr      = cmd_fire && (cmd.mode == klt_pkg::MODE_INSERT) && !table_full;
	assign report_load = (state_q == ST_REPORT) && slot_free;

	assign wr_ent.name     = cmd.item_name;
	assign wr_ent.kind     = cmd.item_kind;
	assign wr_ent.quantity = cmd.item_quantity;

	// per-cell load select: write slot, rotate the ring, or close the gap
	always_comb begin
		for (int i = 0; i < klt_pkg::CAPACITY; i++) begin
			cell_ctl[i].op = klt_pkg::CELL_HOLD;
			if (ins_wr && (klt_pkg::CNT_W'(i) == count_q)) begin
				cell_ctl[i].op = klt_pkg::CELL_WRITE;
			end else if (scan_adv) begin
				cell_ctl[i].op = klt_pkg::CELL_NEXT;
			end else if (shift && (klt_pkg::IDX_W'(i) >= hit_idx_q)) begin
				cell_ctl[i].op = klt_pkg::CELL_NEXT;
			end
		end
	end

	// ring of cells, each fed by the one above it
	for (genvar g = 0; g < klt_pkg::CAPACITY; g++) begin : g_cell
		klt_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[g]),
			.wr_data (wr_ent),
			.nxt     (cell_ent[(g + 1) % klt_pkg::CAPACITY]),
			.ent     (cell_ent[g])
		);
	end

	// single-result responses
	always_comb begin
		pend_d             = '0;
		pend_d.last_of_run = 1'b1;
		pend_d.entry_count = klt_pkg::COUNT_W'(count_q);
		pend_load          = 1'b0;
		if (cmd_fire) begin
			unique case (cmd.mode)
				klt_pkg::MODE_INSERT: begin
					pend_load = 1'b1;
					if (table_full) begin
						pend_d.status = klt_pkg::STATUS_FULL;
					end else begin
						pend_d.status      = klt_pkg::STATUS_OK;
						pend_d.position    = klt_pkg::POS_W'(count_q);
						pend_d.entry_count = klt_pkg::COUNT_W'(count_q + 1'b1);
					end
				end
				klt_pkg::MODE_REMOVE, klt_pkg::MODE_SEARCH, klt_pkg::MODE_LIST: begin
					pend_load     = table_empty;
					pend_d.status = klt_pkg::STATUS_EMPTY;
				end
				default: pend_load = 1'b0;
			endcase
		end else if (state_q == ST_DECIDE) begin
			pend_load = 1'b1;
			if (!found_q) begin
				pend_d.status = klt_pkg::STATUS_NOTFOUND;
			end else if (mode_q == klt_pkg::MODE_REMOVE) begin
				pend_d.status      = klt_pkg::STATUS_OK;
				pend_d.position    = klt_pkg::POS_W'(hit_idx_q);
				pend_d.entry_count = klt_pkg::COUNT_W'(count_q - 1'b1);
			end else begin
				pend_d.status         = klt_pkg::STATUS_OK;
				pend_d.position       = klt_pkg::POS_W'(hit_idx_q);
				pend_d.found_name     = hit_ent_q.name;
				pend_d.found_kind     = hit_ent_q.kind;
				pend_d.found_quantity = hit_ent_q.quantity;
			end
		end
	end

	// list result taken from the head cell
	always_comb begin
		list_rsp                = '0;
		list_rsp.status         = klt_pkg::STATUS_OK;
		list_rsp.position       = klt_pkg::POS_W'(step_q);
		list_rsp.entry_count    = klt_pkg::COUNT_W'(count_q);
		list_rsp.found_name     = cell_ent[0].name;
		list_rsp.found_kind     = cell_ent[0].kind;
		list_rsp.found_quantity = cell_ent[0].quantity;
		list_rsp.last_of_run    = (klt_pkg::CNT_W'(step_q + 1'b1) == count_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ins_wr) begin
				count_q <= count_q + 1'b1;
			end else if (shift) begin
				count_q <= count_q - 1'b1;
			end

			if (list_emit || report_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						step_q  <= '0;
						found_q <= 1'b0;
						if (cmd.mode != klt_pkg::MODE_INSERT && !table_empty) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_REPORT;
						end
					end
				end
				ST_SCAN: begin
					if (scan_adv) begin
						step_q <= step_q + 1'b1;
						if (key_hit) begin
							found_q <= 1'b1;
						end
						if (last_step) begin
							state_q <= list_mode ? ST_IDLE : ST_DECIDE;
						end
					end
				end
				ST_DECIDE: state_q <= ST_REPORT;
				ST_REPORT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			mode_q <= cmd.mode;
			key_q  <= cmd.item_name;
		end
		if (scan_adv && key_hit) begin
			hit_idx_q <= klt_pkg::IDX_W'(step_q);
			hit_ent_q <= cell_ent[0];
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (list_emit) begin
			res_q <= list_rsp;
		end else if (report_load) begin
			res_q <= pend_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`include "keyed_list_table_assert.svh"

	`KLT_ASSERT(a_count_bound, clk, arst_n, count_q <= klt_pkg::CNT_W'(klt_pkg::CAPACITY), "entry count above capacity")
	`KLT_ASSERT(a_count_step, clk, arst_n, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1), "entry count jumped")
	`KLT_ASSERT(a_err_last, clk, arst_n, (res_valid && res.status != klt_pkg::STATUS_OK) |-> res.last_of_run, "error result not last of run")
	`KLT_ASSERT_NEVER(a_load_busy, clk, arst_n, (list_emit || report_load) && res_valid_q && !res_ready, "result register overwritten")
	`KLT_ASSERT(a_scan_exit, clk, arst_n, (state_q == ST_SCAN && scan_adv && last_step && !list_mode) |=> (state_q == ST_DECIDE), "scan did not hand over")

endmodule

// File: dv/tb_keyed_list_table.sv
module tb_keyed_list_table;
	timeunit 1ns;
	timeprecision 1ps;

	import klt_pkg::*;

	localparam int RUN_LIMIT   = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 50;
	localparam int POOL_SIZE   = 6;
	localparam int PHASE_ITEMS = 18;

	// Shadow copy of the table plus the queue of responses it predicts
	class keyed_table_board;
		logic [KEY_W-1:0]        names [CAPACITY];
		logic [KEY_W-1:0]        kinds [CAPACITY];
		logic signed [QTY_W-1:0] qtys  [CAPACITY];
		int unsigned             held;
		rsp_t                    pending_rsp[$];
		int unsigned             errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function void push_rsp(logic [1:0] st, int unsigned pos, int unsigned slot, bit with_entry,
				bit last);
			rsp_t r;
			r = '0;
			r.status = st;
			r.position = pos[POS_W-1:0];
			r.entry_count = held[COUNT_W-1:0];
			if (with_entry) begin
				r.found_name = names[slot];
				r.found_kind = kinds[slot];
				r.found_quantity = qtys[slot];
			end
			r.last_of_run = last;
			pending_rsp.push_back(r);
		endfunction

		// Predict every response caused by one accepted command
		function void note_command(cmd_t c);
			int hit;
			int unsigned n;
			hit = -1;
			case (c.mode)
				MODE_INSERT: begin
					if (held >= CAPACITY) begin
						push_rsp(STATUS_FULL, 0, 0, 0, 1);
					end else begin
						names[held] = c.item_name;
						kinds[held] = c.item_kind;
						qtys[held] = c.item_quantity;
						held++;
						push_rsp(STATUS_OK, held - 1, 0, 0, 1);
					end
				end
				MODE_LIST: begin
					if (held == 0) begin
						push_rsp(STATUS_EMPTY, 0, 0, 0, 1);
					end else begin
						n = (held < 16) ? held : 16;
						for (int unsigned i = 0; i < n; i++)
							push_rsp(STATUS_OK, i, i, 1, i + 1 == n);
					end
				end
				default: begin
					// remove and search share the lookup of the first match
					for (int i = 0; i < held; i++)
						if (hit < 0 && names[i] == c.item_name)
							hit = i;
					if (held == 0) begin
						push_rsp(STATUS_EMPTY, 0, 0, 0, 1);
					end else if (hit < 0) begin
						push_rsp(STATUS_NOTFOUND, 0, 0, 0, 1);
					end else if (c.mode == MODE_SEARCH) begin
						push_rsp(STATUS_OK, hit, hit, 1, 1);
					end else begin
						for (int i = hit; i + 1 < held; i++) begin
							names[i] = names[i + 1];
							kinds[i] = kinds[i + 1];
							qtys[i] = qtys[i + 1];
						end
						held--;
						push_rsp(STATUS_OK, hit, 0, 0, 1);
					end
				end
			endcase
		endfunction

		function void cmp_field(string fld, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %h, actual %h", fld, want, got);
				errors++;
			end
		endfunction

		// Compare one accepted response with the oldest prediction
		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				$error("response with nothing predicted: %h", got);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			cmp_field("status", 64'(want.status), 64'(got.status));
			cmp_field("position", 64'(want.position), 64'(got.position));
			cmp_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
			cmp_field("found_name", want.found_name, got.found_name);
			cmp_field("found_kind", want.found_kind, got.found_kind);
			cmp_field("found_quantity", 64'(unsigned'(want.found_quantity)),
				64'(unsigned'(got.found_quantity)));
			cmp_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	rsp_t res;

	keyed_table_board board = new();

	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	bit hold_request = 0;
	int unsigned cycle_cnt = 0;
	logic [KEY_W-1:0] name_pool[POOL_SIZE];

	keyed_list_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Run guard
	initial begin
		while (cycle_cnt < RUN_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: failure");
		$finish;
	end

	// Response checker
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			board.check_response(res);
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				res_ready <= 1'b0;
				for (int unsigned k = 0; k < HOLD_CYCLES; k++)
					@(negedge clk);
			end
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] m, logic [KEY_W-1:0] nm,
			logic [KEY_W-1:0] kd, logic signed [QTY_W-1:0] q);
		cmd_t c;
		c.mode = m;
		c.item_name = nm;
		c.item_kind = kd;
		c.item_quantity = q;
		return c;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// Mostly pool names so lookups hit; the rest random noise
	function automatic cmd_t random_cmd();
		cmd_t c;
		int unsigned pick;
		pick = $urandom_range(99);
		c.item_name = ($urandom_range(99) < 80) ? name_pool[$urandom_range(POOL_SIZE - 1)]
			: rand_key();
		c.item_kind = rand_key();
		c.item_quantity = $urandom;
		if (pick < 40)
			c.mode = MODE_INSERT;
		else if (pick < 60)
			c.mode = MODE_REMOVE;
		else if (pick < 85)
			c.mode = MODE_SEARCH;
		else
			c.mode = MODE_LIST;
		return c;
	endfunction

	// Offer one transaction; entered and left at a falling edge
	task automatic send_cmd(cmd_t c);
		if ($urandom_range(99) < gap_pct) begin
			cmd_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < gap_pct);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		board.note_command(c);
		@(negedge clk);
	endtask

	// Stimulus
	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			name_pool[i] = rand_key() >> (8 * $urandom_range(7));
		@(posedge arst_n);
		@(negedge clk);

		// Directed: empty table, fill with extremes and duplicates, full table
		send_cmd(make_cmd(MODE_LIST, '0, '0, '0));
		send_cmd(make_cmd(MODE_SEARCH, '1, '0, '0));
		send_cmd(make_cmd(MODE_REMOVE, '0, '0, '0));
		send_cmd(make_cmd(MODE_INSERT, '0, '0, 32'sh8000_0000));
		send_cmd(make_cmd(MODE_INSERT, '1, '1, 32'sh7fff_ffff));
		send_cmd(make_cmd(MODE_INSERT, 64'h6162, rand_key(), '0));
		send_cmd(make_cmd(MODE_INSERT, '0, rand_key(), -32'sd1));
		for (int i = 4; i < CAPACITY; i++)
			send_cmd(make_cmd(MODE_INSERT, name_pool[i % POOL_SIZE], rand_key(), $urandom));
		send_cmd(make_cmd(MODE_INSERT, 64'h7a7a, '1, 32'sd5));
		send_cmd(make_cmd(MODE_LIST, '0, '0, '0));
		send_cmd(make_cmd(MODE_SEARCH, '0, '0, '0));
		send_cmd(make_cmd(MODE_SEARCH, 64'h1234_5678_9abc_def0, '0, '0));
		send_cmd(make_cmd(MODE_REMOVE, '1, '0, '0));
		send_cmd(make_cmd(MODE_REMOVE, 64'h1234_5678_9abc_def0, '0, '0));
		send_cmd(make_cmd(MODE_REMOVE, '0, '0, '0));
		send_cmd(make_cmd(MODE_SEARCH, '0, '0, '0));

		// Random phases: none but one long receiver hold-off, sender gaps, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  hold_request = 1; end
				1: begin gap_pct = 83; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 83; end
				default: begin gap_pct = 21; stall_pct = 21; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_cmd(random_cmd());
		end
		cmd_valid <= 1'b0;

		// Drain outstanding responses, then a short settle
		while (board.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/klt_pkg.sv
hdl/klt_cell.sv
hdl/keyed_list_table.sv
dv/tb_keyed_list_table.sv
